/* hdl/qt2m_pkg.sv */
// Shared types, widths and helpers of the quaternion-to-matrix pipeline.
package qt2m_pkg;

  localparam int WORD_W = 32;
  localparam int PROD_W = 64;
  localparam int SUM_W  = 66;
  localparam int NPROD  = 6;
  localparam int NCOL   = 3;

  // Combine rule of the two products that feed one matrix entry
  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_DIAG,
    OP_PASS
  } op_e;

  typedef struct packed {
    logic [1:0] row;
    logic       last;
  } row_tag_t;

  // One matrix row on its way into the product stage
  typedef struct packed {
    row_tag_t                        tag;
    op_e      [NCOL-1:0]             op;
    logic     [NPROD-1:0][WORD_W-1:0] opa;
    logic     [NPROD-1:0][WORD_W-1:0] opb;
    logic     [WORD_W-1:0]           scale;
  } issue_t;

  // One row of saturated rotation terms, ready for scaling
  typedef struct packed {
    row_tag_t                       tag;
    logic     [WORD_W-1:0]          scale;
    logic     [NCOL-1:0][WORD_W-1:0] term;
  } term_t;

  function automatic logic [WORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic fits;
    fits = (&v[SUM_W-1:WORD_W-1]) || !(|v[SUM_W-1:WORD_W-1]);
    if (fits) begin
      sat32 = v[WORD_W-1:0];
    end else if (v[SUM_W-1]) begin
      sat32 = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      sat32 = {1'b0, {(WORD_W-1){1'b1}}};
    end
  endfunction

endpackage

/* hdl/quaternion_transform_to_matrix_unit.sv */
// Top level: transform (translation, quaternion, scale) to 4x4 matrix rows.
// Rows pass the issue register and stages S1 to S4 and leave in order, row 0 first, row 3 last.
// Throughput: the row sequencer feeds one row a cycle while the pipeline is not stalled, and it
// takes the next transform in the same cycle as the last row of the current one issues.
// Reset: rst_ni clears all valid bits and the row counter; data registers keep their contents.
module quaternion_transform_to_matrix_unit
  import qt2m_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [WORD_W-1:0] trans_x_i,
  input  logic [WORD_W-1:0] trans_y_i,
  input  logic [WORD_W-1:0] trans_z_i,
  input  logic [WORD_W-1:0] quat_x_i,
  input  logic [WORD_W-1:0] quat_y_i,
  input  logic [WORD_W-1:0] quat_z_i,
  input  logic [WORD_W-1:0] quat_w_i,
  input  logic [WORD_W-1:0] scale_x_i,
  input  logic [WORD_W-1:0] scale_y_i,
  input  logic [WORD_W-1:0] scale_z_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        row_index_o,
  output logic [WORD_W-1:0] col0_o,
  output logic [WORD_W-1:0] col1_o,
  output logic [WORD_W-1:0] col2_o,
  output logic [WORD_W-1:0] col3_o,
  output logic              last_row_o
);

  // Pipeline outline:
  //   issue  - holds the accepted transform, steps through rows 0..3, one row per transfer
  //   S1     - six 32x32 products of quaternion components (translation row: trans * 0.5)
  //   S2     - doubled products combined into three rotation terms, saturated to 32 bits
  //   S3     - each term times the axis scale of its row
  //   S4     - floor shift by FRAC_BITS, saturate, output register
  // Each stage has its own valid bit and advances when the stage after it is empty or
  // moving, so bubbles collapse and a stall holds every row in place.

  issue_t iss;
  logic   iss_valid, iss_ready;
  term_t  trm;
  logic   trm_valid, trm_ready;

  qt2m_issue #(
    .FRAC_BITS (FRAC_BITS)
  ) u_issue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .trans_x_i   (trans_x_i),
    .trans_y_i   (trans_y_i),
    .trans_z_i   (trans_z_i),
    .quat_x_i    (quat_x_i),
    .quat_y_i    (quat_y_i),
    .quat_z_i    (quat_z_i),
    .quat_w_i    (quat_w_i),
    .scale_x_i   (scale_x_i),
    .scale_y_i   (scale_y_i),
    .scale_z_i   (scale_z_i),
    .iss_valid_o (iss_valid),
    .iss_ready_i (iss_ready),
    .iss_o       (iss)
  );

  // Rotation terms: products, then add/subtract and clamp
  qt2m_term #(
    .FRAC_BITS (FRAC_BITS)
  ) u_term (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .iss_valid_i (iss_valid),
    .iss_ready_o (iss_ready),
    .iss_i       (iss),
    .trm_valid_o (trm_valid),
    .trm_ready_i (trm_ready),
    .trm_o       (trm)
  );

  // Per-row scaling and the output register
  qt2m_scale #(
    .FRAC_BITS (FRAC_BITS)
  ) u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .trm_valid_i (trm_valid),
    .trm_ready_o (trm_ready),
    .trm_i       (trm),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .row_index_o (row_index_o),
    .col0_o      (col0_o),
    .col1_o      (col1_o),
    .col2_o      (col2_o),
    .col3_o      (col3_o),
    .last_row_o  (last_row_o)
  );

endmodule

/* hdl/qt2m_issue.sv */
// Row sequencer: holds one transform and issues its four matrix rows in order.
module qt2m_issue
  import qt2m_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [WORD_W-1:0]   trans_x_i,
  input  logic [WORD_W-1:0]   trans_y_i,
  input  logic [WORD_W-1:0]   trans_z_i,
  input  logic [WORD_W-1:0]   quat_x_i,
  input  logic [WORD_W-1:0]   quat_y_i,
  input  logic [WORD_W-1:0]   quat_z_i,
  input  logic [WORD_W-1:0]   quat_w_i,
  input  logic [WORD_W-1:0]   scale_x_i,
  input  logic [WORD_W-1:0]   scale_y_i,
  input  logic [WORD_W-1:0]   scale_z_i,
  output logic                iss_valid_o,
  input  logic                iss_ready_i,
  output issue_t              iss_o
);

  // Half and one in fixed point: trans * half, doubled and truncated, is trans itself
  localparam logic [WORD_W-1:0] Half = WORD_W'(1) << (FRAC_BITS - 1);
  localparam logic [WORD_W-1:0] One  = WORD_W'(1) << FRAC_BITS;

  logic              item_valid_q, item_valid_d;
  logic [1:0]        row_q, row_d;
  logic [WORD_W-1:0] tx_q, ty_q, tz_q, qx_q, qy_q, qz_q, qw_q, sx_q, sy_q, sz_q;
  logic              fire, in_fire, done;

  assign fire        = item_valid_q && iss_ready_i;
  assign done        = fire && (row_q == 2'd3);
  assign in_ready_o  = !item_valid_q || done;
  assign in_fire     = in_valid_i && in_ready_o;
  assign iss_valid_o = item_valid_q;

  always_comb begin
    item_valid_d = item_valid_q;
    row_d        = row_q;
    if (fire) begin
      row_d = row_q + 2'd1;
    end
    if (in_fire) begin
      item_valid_d = 1'b1;
    end else if (done) begin
      item_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      row_q        <= 2'd0;
    end else begin
      item_valid_q <= item_valid_d;
      row_q        <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      tx_q <= trans_x_i;
      ty_q <= trans_y_i;
      tz_q <= trans_z_i;
      qx_q <= quat_x_i;
      qy_q <= quat_y_i;
      qz_q <= quat_z_i;
      qw_q <= quat_w_i;
      sx_q <= scale_x_i;
      sy_q <= scale_y_i;
      sz_q <= scale_z_i;
    end
  end

  // Pick the six quaternion products and the scale of the current row
  always_comb begin
    iss_o          = '0;
    iss_o.tag.row  = row_q;
    iss_o.tag.last = (row_q == 2'd3);
    case (row_q)
      2'd0: begin
        iss_o.opa[0] = qy_q; iss_o.opb[0] = qy_q;
        iss_o.opa[1] = qz_q; iss_o.opb[1] = qz_q;
        iss_o.opa[2] = qx_q; iss_o.opb[2] = qy_q;
        iss_o.opa[3] = qw_q; iss_o.opb[3] = qz_q;
        iss_o.opa[4] = qx_q; iss_o.opb[4] = qz_q;
        iss_o.opa[5] = qw_q; iss_o.opb[5] = qy_q;
        iss_o.op[0]  = OP_DIAG;
        iss_o.op[1]  = OP_ADD;
        iss_o.op[2]  = OP_SUB;
        iss_o.scale  = sx_q;
      end
      2'd1: begin
        iss_o.opa[0] = qx_q; iss_o.opb[0] = qy_q;
        iss_o.opa[1] = qw_q; iss_o.opb[1] = qz_q;
        iss_o.opa[2] = qx_q; iss_o.opb[2] = qx_q;
        iss_o.opa[3] = qz_q; iss_o.opb[3] = qz_q;
        iss_o.opa[4] = qy_q; iss_o.opb[4] = qz_q;
        iss_o.opa[5] = qw_q; iss_o.opb[5] = qx_q;
        iss_o.op[0]  = OP_SUB;
        iss_o.op[1]  = OP_DIAG;
        iss_o.op[2]  = OP_ADD;
        iss_o.scale  = sy_q;
      end
      2'd2: begin
        iss_o.opa[0] = qx_q; iss_o.opb[0] = qz_q;
        iss_o.opa[1] = qw_q; iss_o.opb[1] = qy_q;
        iss_o.opa[2] = qy_q; iss_o.opb[2] = qz_q;
        iss_o.opa[3] = qw_q; iss_o.opb[3] = qx_q;
        iss_o.opa[4] = qx_q; iss_o.opb[4] = qx_q;
        iss_o.opa[5] = qy_q; iss_o.opb[5] = qy_q;
        iss_o.op[0]  = OP_ADD;
        iss_o.op[1]  = OP_SUB;
        iss_o.op[2]  = OP_DIAG;
        iss_o.scale  = sz_q;
      end
      default: begin
        // translation row: pass trans through the same arithmetic unchanged
        iss_o.opa[0] = tx_q; iss_o.opb[0] = Half;
        iss_o.opa[2] = ty_q; iss_o.opb[2] = Half;
        iss_o.opa[4] = tz_q; iss_o.opb[4] = Half;
        iss_o.op[0]  = OP_PASS;
        iss_o.op[1]  = OP_PASS;
        iss_o.op[2]  = OP_PASS;
        iss_o.scale  = One;
      end
    endcase
  end

endmodule

/* hdl/qt2m_term.sv */
// Product and combine stages: six doubled products, then three saturated rotation terms.
module qt2m_term
  import qt2m_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   iss_valid_i,
  output logic   iss_ready_o,
  input  issue_t iss_i,
  output logic   trm_valid_o,
  input  logic   trm_ready_i,
  output term_t  trm_o
);

  localparam logic signed [SUM_W-1:0] OneExt = SUM_W'(1) << FRAC_BITS;

  logic                            v1_q, v2_q, rdy1, rdy2;
  row_tag_t                        tag1_q;
  op_e      [NCOL-1:0]             op1_q;
  logic     [WORD_W-1:0]           scale1_q;
  logic     [NPROD-1:0][PROD_W-1:0] prod1_q, prod1_d;
  term_t                           trm_q;
  logic     [NCOL-1:0][WORD_W-1:0] term_d;

  assign rdy2        = !v2_q || trm_ready_i;
  assign rdy1        = !v1_q || rdy2;
  assign iss_ready_o = rdy1;
  assign trm_valid_o = v2_q;
  assign trm_o       = trm_q;

  always_comb begin
    for (int j = 0; j < NPROD; j++) begin
      prod1_d[j] = $signed(iss_i.opa[j]) * $signed(iss_i.opb[j]);
    end
  end

  always_comb begin
    logic signed [PROD_W-1:0] sha, shb;
    logic signed [SUM_W-1:0]  pa, pb, sum;
    for (int c = 0; c < NCOL; c++) begin
      sha = $signed(prod1_q[2*c]) >>> (FRAC_BITS - 1);
      shb = $signed(prod1_q[2*c+1]) >>> (FRAC_BITS - 1);
      pa  = $signed({{(SUM_W-PROD_W){sha[PROD_W-1]}}, sha});
      pb  = $signed({{(SUM_W-PROD_W){shb[PROD_W-1]}}, shb});
      case (op1_q[c])
        OP_ADD:  sum = pa + pb;
        OP_SUB:  sum = pa - pb;
        OP_DIAG: sum = OneExt - (pa + pb);
        default: sum = pa;
      endcase
      term_d[c] = sat32(sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= iss_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && iss_valid_i) begin
      tag1_q   <= iss_i.tag;
      op1_q    <= iss_i.op;
      scale1_q <= iss_i.scale;
      prod1_q  <= prod1_d;
    end
    if (rdy2 && v1_q) begin
      trm_q.tag   <= tag1_q;
      trm_q.scale <= scale1_q;
      trm_q.term  <= term_d;
    end
  end

endmodule

/* hdl/qt2m_scale.sv */
// Scale stages: term times axis scale, then truncate, saturate and drive the result row.
module qt2m_scale
  import qt2m_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              trm_valid_i,
  output logic              trm_ready_o,
  input  term_t             trm_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        row_index_o,
  output logic [WORD_W-1:0] col0_o,
  output logic [WORD_W-1:0] col1_o,
  output logic [WORD_W-1:0] col2_o,
  output logic [WORD_W-1:0] col3_o,
  output logic              last_row_o
);

  localparam logic [WORD_W-1:0] One = WORD_W'(1) << FRAC_BITS;

  logic                             v3_q, v4_q, rdy3, rdy4;
  row_tag_t                         tag3_q, tag4_q;
  logic     [NCOL-1:0][PROD_W-1:0]  prod3_q, prod3_d;
  logic     [NCOL-1:0][WORD_W-1:0]  col4_q, col4_d;

  assign rdy4        = !v4_q || out_ready_i;
  assign rdy3        = !v3_q || rdy4;
  assign trm_ready_o = rdy3;

  always_comb begin
    for (int c = 0; c < NCOL; c++) begin
      prod3_d[c] = $signed(trm_i.term[c]) * $signed(trm_i.scale);
    end
  end

  always_comb begin
    logic signed [PROD_W-1:0] sh;
    for (int c = 0; c < NCOL; c++) begin
      sh        = $signed(prod3_q[c]) >>> FRAC_BITS;
      col4_d[c] = sat32($signed({{(SUM_W-PROD_W){sh[PROD_W-1]}}, sh}));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy3) begin
        v3_q <= trm_valid_i;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && trm_valid_i) begin
      tag3_q  <= trm_i.tag;
      prod3_q <= prod3_d;
    end
    if (rdy4 && v3_q) begin
      tag4_q <= tag3_q;
      col4_q <= col4_d;
    end
  end

  assign out_valid_o = v4_q;
  assign row_index_o = tag4_q.row;
  assign last_row_o  = tag4_q.last;
  assign col0_o      = col4_q[0];
  assign col1_o      = col4_q[1];
  assign col2_o      = col4_q[2];
  assign col3_o      = tag4_q.last ? One : '0;

endmodule

/* hdl/qt2m_checker.sv */
// Port-level checker of the quaternion-to-matrix unit and its bind.
module qt2m_checker #(
  parameter int FRAC_BITS = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  row_index_o,
  input logic [31:0] col0_o,
  input logic [31:0] col3_o,
  input logic        last_row_o
);

  localparam logic [31:0] One = 32'd1 << FRAC_BITS;

  logic [1:0] exp_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_row_q <= 2'd0;
    end else if (out_valid_o && out_ready_i) begin
      exp_row_q <= exp_row_q + 2'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(row_index_o) && $stable(col0_o))
    else $error("output row changed while stalled");

  a_row_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> row_index_o == exp_row_q)
    else $error("matrix rows out of order");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> last_row_o == (row_index_o == 2'd3))
    else $error("last_row does not match row 3");

  a_col3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> col3_o == (last_row_o ? One : 32'd0))
    else $error("column 3 value wrong");

endmodule

bind quaternion_transform_to_matrix_unit qt2m_checker #(
  .FRAC_BITS (FRAC_BITS)
) u_qt2m_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .row_index_o (row_index_o),
  .col0_o      (col0_o),
  .col3_o      (col3_o),
  .last_row_o  (last_row_o)
);

/* tb/quaternion_transform_to_matrix_unit_test.sv */
// Self-checking testbench for the quaternion transform to matrix row unit.
`timescale 1ns / 100ps

module quaternion_transform_to_matrix_unit_test
  import qt2m_pkg::*;
;

  localparam int FRAC_BITS = 16;
  localparam int UNIT      = 1 << FRAC_BITS;       // 1.0 in fixed point
  localparam int HALF_SQRT = 46341;                // about sqrt(0.5)
  localparam int WORD_MAX  = 32'sh7FFF_FFFF;
  localparam int WORD_MIN  = 32'sh8000_0000;
  localparam logic signed [63:0] WIDE_MAX  = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] WIDE_MIN  = 64'shFFFF_FFFF_8000_0000;
  localparam logic [1:0]         LAST_ROW  = 2'd3;
  localparam int                 DIRECTED_COUNT = 17;
  localparam int                 XFORM_COUNT    = 380;
  localparam int                 DRAIN_CYCLES   = 24;

  // One transform as it goes onto the input pins
  typedef struct {
    logic signed [31:0] trans_x, trans_y, trans_z;
    logic signed [31:0] quat_x, quat_y, quat_z, quat_w;
    logic signed [31:0] scale_x, scale_y, scale_z;
  } xform_t;

  // One matrix row as it comes off the output pins
  typedef struct {
    logic [1:0]  row_index;
    logic [31:0] col0, col1, col2, col3;
    logic        last_row;
  } mrow_t;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic out_ready_i = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  logic [1:0]        row_index_o;
  logic [WORD_W-1:0] col0_o, col1_o, col2_o, col3_o;
  logic              last_row_o;

  xform_t xform_drv = '{default: '0};

  xform_t xform_pending[$];     // transforms not yet offered to the block
  mrow_t  matrix_expected[$];   // predicted rows, oldest first
  logic   in_taken = 1'b0;      // input transfer at the last rising edge
  int     fault_count = 0;
  int     in_gap = 0;
  int     in_calm = 0;
  int     out_stall = 0;
  int     out_calm = 0;

  quaternion_transform_to_matrix_unit #(
    .FRAC_BITS(FRAC_BITS)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .trans_x_i  (xform_drv.trans_x),
    .trans_y_i  (xform_drv.trans_y),
    .trans_z_i  (xform_drv.trans_z),
    .quat_x_i   (xform_drv.quat_x),
    .quat_y_i   (xform_drv.quat_y),
    .quat_z_i   (xform_drv.quat_z),
    .quat_w_i   (xform_drv.quat_w),
    .scale_x_i  (xform_drv.scale_x),
    .scale_y_i  (xform_drv.scale_y),
    .scale_z_i  (xform_drv.scale_z),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .row_index_o(row_index_o),
    .col0_o     (col0_o),
    .col1_o     (col1_o),
    .col2_o     (col2_o),
    .col3_o     (col3_o),
    .last_row_o (last_row_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Matrix predictor
  // ---------------------------------------------------------------------------

  // floor(2*a*b / 2^F): exact 64-bit product, arithmetic shift rounds down
  function automatic logic signed [63:0] twice_prod(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
    logic signed [63:0] wa, wb;
    wa = a;
    wb = b;
    return (wa * wb) >>> (FRAC_BITS - 1);
  endfunction

  function automatic logic signed [31:0] clamp_word(input logic signed [63:0] v);
    if (v > WIDE_MAX) return WORD_MAX;
    if (v < WIDE_MIN) return WORD_MIN;
    return v[31:0];
  endfunction

  // Clamp the rotation term first, then scale, round down and clamp again
  function automatic logic signed [31:0] scale_term(input logic signed [63:0] term,
                                                    input logic signed [31:0] scale);
    logic signed [63:0] wt, ws;
    wt = clamp_word(term);
    ws = scale;
    return clamp_word((wt * ws) >>> FRAC_BITS);
  endfunction

  function automatic mrow_t make_row(input logic [1:0] idx, input logic [31:0] c0,
                                     input logic [31:0] c1, input logic [31:0] c2,
                                     input logic [31:0] c3);
    mrow_t r;
    r.row_index = idx;
    r.col0      = c0;
    r.col1      = c1;
    r.col2      = c2;
    r.col3      = c3;
    r.last_row  = (idx == LAST_ROW);
    return r;
  endfunction

  // Work out the four rows of one transform and queue them in order
  task automatic push_matrix_rows(input xform_t x);
    logic signed [63:0] xx, yy, zz, yz, wx, xy, wz, xz, wy, one;
    one = 64'sd1 <<< FRAC_BITS;
    xx  = twice_prod(x.quat_x, x.quat_x);
    yy  = twice_prod(x.quat_y, x.quat_y);
    zz  = twice_prod(x.quat_z, x.quat_z);
    yz  = twice_prod(x.quat_y, x.quat_z);
    wx  = twice_prod(x.quat_w, x.quat_x);
    xy  = twice_prod(x.quat_x, x.quat_y);
    wz  = twice_prod(x.quat_w, x.quat_z);
    xz  = twice_prod(x.quat_x, x.quat_z);
    wy  = twice_prod(x.quat_w, x.quat_y);
    matrix_expected.push_back(make_row(2'd0,
      scale_term(one - (yy + zz), x.scale_x),
      scale_term(xy + wz, x.scale_x),
      scale_term(xz - wy, x.scale_x), '0));
    matrix_expected.push_back(make_row(2'd1,
      scale_term(xy - wz, x.scale_y),
      scale_term(one - (xx + zz), x.scale_y),
      scale_term(yz + wx, x.scale_y), '0));
    matrix_expected.push_back(make_row(2'd2,
      scale_term(xz + wy, x.scale_z),
      scale_term(yz - wx, x.scale_z),
      scale_term(one - (xx + yy), x.scale_z), '0));
    // Translation and the homogeneous 1.0 pass straight through
    matrix_expected.push_back(make_row(LAST_ROW, x.trans_x, x.trans_y, x.trans_z,
                                       one[31:0]));
  endtask

  function automatic void match_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      fault_count++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly back-to-back, sometimes a few cycles, rarely a long pause
  function automatic int draw_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int rand_span(input int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  function automatic int corner_word();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 1;
      2: return -1;
      3: return UNIT;
      4: return -UNIT;
      5: return WORD_MAX;
      6: return WORD_MIN;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_xform(input int tx, input int ty, input int tz, input int qx,
                            input int qy, input int qz, input int qw, input int sx,
                            input int sy, input int sz);
    xform_t x;
    x.trans_x = tx;
    x.trans_y = ty;
    x.trans_z = tz;
    x.quat_x  = qx;
    x.quat_y  = qy;
    x.quat_z  = qz;
    x.quat_w  = qw;
    x.scale_x = sx;
    x.scale_y = sy;
    x.scale_z = sz;
    xform_pending.push_back(x);
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: change pins on the falling edge, hold until the transfer
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (xform_pending.size() != 0) begin
          xform_drv  <= xform_pending.pop_front();
          in_valid_i <= 1'b1;
          // Drop into a calm stretch now and then so full rate is covered too
          if (in_calm > 0) begin
            in_calm--;
            in_gap = 0;
          end else begin
            if ($urandom_range(0, 39) == 0) in_calm = 30;
            in_gap = draw_gap();
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output back-pressure: stall ready at random, independent of out_valid_o
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_stall > 0) begin
        out_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (out_calm > 0) begin
          out_calm--;
        end else begin
          if ($urandom_range(0, 39) == 0) out_calm = 40;
          out_stall = draw_gap();
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample both channels on the rising edge, predict and check
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    mrow_t want;
    if (rst_ni) begin
      in_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        push_matrix_rows(xform_drv);
      end
      if (out_valid_o && out_ready_i) begin
        if (matrix_expected.size() == 0) begin
          $error("matrix row %0d arrived with no transform pending", row_index_o);
          fault_count++;
        end else begin
          want = matrix_expected.pop_front();
          match_field("row_index", 32'(want.row_index), 32'(row_index_o));
          match_field("col0", want.col0, col0_o);
          match_field("col1", want.col1, col1_o);
          match_field("col2", want.col2, col2_o);
          match_field("col3", want.col3, col3_o);
          match_field("last_row", 32'(want.last_row), 32'(last_row_o));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int kind;
    // Directed: extremes, rotations about each axis, rounding and clamping
    push_xform(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    push_xform(UNIT, -UNIT, 3 * UNIT, 0, 0, 0, UNIT, UNIT, UNIT, UNIT);
    push_xform(5, -7, 11, 0, 0, HALF_SQRT, HALF_SQRT, 2 * UNIT, 2 * UNIT, 2 * UNIT);
    push_xform(-UNIT, 0, UNIT, HALF_SQRT, 0, 0, HALF_SQRT, -UNIT, -UNIT, -UNIT);
    push_xform(1, 2, 3, 0, -HALF_SQRT, 0, HALF_SQRT, UNIT / 2, UNIT / 2, UNIT / 2);
    // Tiny odd products: the doubled terms round toward minus infinity
    push_xform(0, 0, 0, -1, 1, -3, 5, UNIT, UNIT, UNIT);
    // Smallest scales: 1.0 times -1 LSB stays -1 LSB, times +1 LSB stays +1 LSB
    push_xform(0, 0, 0, 0, 0, 0, UNIT, -1, 1, -1);
    push_xform(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX,
               WORD_MAX, WORD_MAX, WORD_MAX);
    push_xform(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN,
               WORD_MIN, WORD_MIN, WORD_MIN);
    push_xform(WORD_MAX, WORD_MIN, 0, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN,
               WORD_MIN, WORD_MAX, 0);
    // Rotation terms in range but the scaled entry clamps
    push_xform(0, 0, 0, 2 * UNIT, 0, 0, 0, WORD_MAX, WORD_MIN, UNIT);
    // Non-unit quaternion, no normalization
    push_xform(UNIT, UNIT, UNIT, UNIT, UNIT, UNIT, UNIT, UNIT, UNIT, UNIT);
    push_xform(7, 8, 9, 0, 0, 0, -UNIT, -UNIT, 3 * UNIT, -5 * UNIT);
    // Rotation terms clamp before a tiny scale
    push_xform(0, 0, 0, 1 << 24, -(1 << 24), 1 << 24, 1 << 24, 1, -1, 2);
    push_xform(WORD_MIN, WORD_MAX, -1, 0, 0, 0, 0, 0, 0, 0);
    push_xform(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1);
    push_xform(0, 0, 0, WORD_MAX, 0, 0, 0, UNIT, UNIT, UNIT);

    // Random: half with quaternion parts within +-1.0, the rest full-range, large and corner words
    repeat (XFORM_COUNT - DIRECTED_COUNT) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        push_xform($urandom, $urandom, $urandom,
                   rand_span(UNIT), rand_span(UNIT), rand_span(UNIT), rand_span(UNIT),
                   rand_span(4 * UNIT), rand_span(4 * UNIT), rand_span(4 * UNIT));
      end else if (kind < 7) begin
        push_xform($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom);
      end else if (kind < 9) begin
        push_xform(rand_span(1 << 24), rand_span(1 << 24), rand_span(1 << 24),
                   rand_span(1 << 24), rand_span(1 << 24), rand_span(1 << 24),
                   rand_span(1 << 24), $urandom, $urandom, $urandom);
      end else begin
        push_xform(corner_word(), corner_word(), corner_word(), corner_word(),
                   corner_word(), corner_word(), corner_word(), corner_word(),
                   corner_word(), corner_word());
      end
    end

    // Hold reset, then release it on a falling edge
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait for the last transfer in, then for every row out, then drain
    while (xform_pending.size() != 0 || in_valid_i) @(negedge clk_i);
    while (matrix_expected.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fault_count == 0 && matrix_expected.size() == 0) begin
      $display("quaternion_transform_to_matrix_unit verification clean");
    end else begin
      $display("quaternion_transform_to_matrix_unit verification failed");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run
  initial begin
    #5_000_000;
    $display("quaternion_transform_to_matrix_unit verification failed");
    $finish;
  end

endmodule
